// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the resampler modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the systematic resampler.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int FRAC_BITS         = 24;
    localparam int SUM_W             = 32;
    localparam int WEIGHT_W          = 25;
    localparam int OFFSET_W          = 24;
    localparam int STEP_W            = 25;
    localparam int MODE_W            = 2;
    localparam int IDX_W             = 10;
    localparam int S_TDATA_W         = 56;
    localparam int M_TDATA_W         = 16;
    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [STEP_W-1:0] ONE_VAL    = STEP_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16384);

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_DRAW
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [WEIGHT_W-1:0]   weight;
        logic                  first;
        logic [OFFSET_W-1:0]   offset;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

endpackage

// ===== design/systematic_resampler.sv =====
// Draw path: a draw is taken in the idle state, the scan state then steps over the
// entries whose prefix sum lies below the pointer, and the index is registered once
// the output is free; loads and starts are registered on acceptance, 1 per cycle
// while idle. A draw holds the scan unit, and no command is taken until it is done.
// Reset: rst_n asynchronous, active low; clears counters, pointer, queue and output
// valid, the pointer step returns to 16384; the prefix-sum store is not cleared.
// ----------------------------------------------------------------------------
// systematic_resampler
// Particle-filter systematic resampling: prefix-sum load, start and draw.
// ----------------------------------------------------------------------------
module systematic_resampler #(
    parameter int MAX_PARTICLES = srs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srs_pkg::STEP_W-1:0]       cfg_wdata,    // pointer step
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srs_pkg::S_TDATA_W-1:0]    s_tdata,      // weight, first, offset
    input  logic [srs_pkg::MODE_W-1:0]       s_tuser,      // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srs_pkg::M_TDATA_W-1:0]    m_tdata,      // index
    output logic                             m_tlast       // last
);
    import srs_pkg::*;

    localparam int W_LO = 0;
    localparam int F_LO = W_LO + WEIGHT_W;
    localparam int O_LO = F_LO + 1;

    cmd_t             push_cmd;
    cmd_t             pop_cmd;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    logic [IDX_W-1:0] index;

    srs_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .mode       (s_tuser),
        .weight     (s_tdata[F_LO-1:W_LO]),
        .first      (s_tdata[F_LO]),
        .offset     (s_tdata[O_LO+OFFSET_W-1:O_LO]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    srs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    srs_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - IDX_W){1'b0}}, index};

endmodule

// ===== design/srs_front.sv =====
// ----------------------------------------------------------------------------
// srs_front
// Input side: decodes the mode of each transaction into a command and
// pushes it into the command queue. Unknown modes are accepted and dropped.
// ----------------------------------------------------------------------------
module srs_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [srs_pkg::MODE_W-1:0]     mode,
    input  logic [srs_pkg::WEIGHT_W-1:0]   weight,
    input  logic                           first,
    input  logic [srs_pkg::OFFSET_W-1:0]   offset,
    output logic                           push_valid,
    input  logic                           push_ready,
    output srs_pkg::cmd_t                  push_cmd
);
    import srs_pkg::*;

    logic keep;

    always_comb
    begin
        push_cmd.weight = weight;
        push_cmd.first  = first;
        push_cmd.offset = offset;
        push_cmd.kind   = CMD_LOAD;
        keep            = 1'b1;
        unique case (mode)
            MODE_LOAD:  push_cmd.kind = CMD_LOAD;
            MODE_START: push_cmd.kind = CMD_START;
            MODE_DRAW:  push_cmd.kind = CMD_DRAW;
            default:    keep          = 1'b0;
        endcase
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && keep;

endmodule

// ===== design/srs_queue.sv =====
// ----------------------------------------------------------------------------
// srs_queue
// Short command FIFO between the decode front and the execution back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srs_queue #(
    parameter int DEPTH = srs_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  srs_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output srs_pkg::cmd_t  pop_cmd
);
    import srs_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    cmd_t            slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SRS_ASSERT_IMPL(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNTW'(DEPTH))

endmodule

// ===== design/srs_back.sv =====
// ----------------------------------------------------------------------------
// srs_back
// Execution side: prefix-sum store, draw pointer and forward scan.
// Loads and starts retire in the idle state; a draw scans one entry per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srs_back #(
    parameter int MAX_PARTICLES = srs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srs_pkg::STEP_W-1:0]    cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  srs_pkg::cmd_t                 cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srs_pkg::IDX_W-1:0]     out_index,
    output logic                          out_last
);
    import srs_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = AW + 1;

    logic [SUM_W-1:0]     sum_mem [MAX_PARTICLES];
    logic [SUM_W-1:0]     rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SUM_W-1:0]     mem_wdata;

    back_state_t          state_reg, state_next;
    logic [CW-1:0]        loaded_reg, loaded_next;
    logic [SUM_W-1:0]     total_reg, total_next;
    logic [FRAC_BITS-1:0] ptr_reg, ptr_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        draws_reg, draws_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_index_reg, out_index_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 draw_ok;
    logic                 advance;
    logic [CW-1:0]        pos_ext;
    logic [CW-1:0]        pos_inc;
    logic [CW-1:0]        last_idx;
    logic [AW-1:0]        start_pos;
    logic [CW-1:0]        draws_inc;
    logic [SUM_W-1:0]     ptr_ext;
    logic [STEP_W-1:0]    ptr_sum;
    logic [IDX_W+AW-1:0]  index_wide;
    logic [CW-1:0]        base_count;
    logic [SUM_W-1:0]     base_total;
    logic [SUM_W:0]       load_sum;
    logic [SUM_W-1:0]     load_sat;
    logic                 is_draw;

    assign out_free   = !out_valid_reg || out_ready;
    assign draw_ok    = (loaded_reg != '0) && (draws_reg < loaded_reg);
    assign pos_ext    = {1'b0, pos_reg};
    assign pos_inc    = pos_ext + CW'(1);
    assign last_idx   = loaded_reg - CW'(1);
    assign start_pos  = (pos_ext >= loaded_reg) ? last_idx[AW-1:0] : pos_reg;
    assign draws_inc  = draws_reg + CW'(1);
    assign ptr_ext    = {{(SUM_W - FRAC_BITS){1'b0}}, ptr_reg};
    assign advance    = (pos_inc < loaded_reg) && (ptr_ext > rd_data_reg);
    assign ptr_sum    = {{(STEP_W - FRAC_BITS){1'b0}}, ptr_reg} + step_reg;
    assign index_wide = {{IDX_W{1'b0}}, pos_reg};
    assign base_count = cmd.first ? '0 : loaded_reg;
    assign base_total = cmd.first ? '0 : total_reg;
    assign load_sum   = {1'b0, base_total} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, cmd.weight};
    assign load_sat   = load_sum[SUM_W] ? {SUM_W{1'b1}} : load_sum[SUM_W-1:0];
    assign is_draw    = cmd_valid && (cmd.kind == CMD_DRAW);

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_last   = out_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_draw && draw_ok)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!advance && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        loaded_next    = loaded_reg;
        total_next     = total_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        draws_next     = draws_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        rd_addr        = pos_reg;
        mem_we         = 1'b0;
        mem_waddr      = base_count[AW-1:0];
        mem_wdata      = load_sat;

        if (cfg_we)
        begin
            step_next = (cfg_wdata > ONE_VAL) ? ONE_VAL : cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_LOAD:
                        begin
                            if (cmd.first)
                            begin
                                loaded_next = '0;
                                total_next  = '0;
                                pos_next    = '0;
                                draws_next  = '0;
                            end
                            if (base_count != CW'(MAX_PARTICLES))
                            begin
                                mem_we      = 1'b1;
                                total_next  = load_sat;
                                loaded_next = base_count + CW'(1);
                            end
                        end
                        CMD_START:
                        begin
                            ptr_next   = cmd.offset[FRAC_BITS-1:0];
                            pos_next   = '0;
                            draws_next = '0;
                        end
                        CMD_DRAW:
                        begin
                            if (draw_ok)
                            begin
                                pos_next = start_pos;
                                rd_addr  = start_pos;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    pos_next = pos_inc[AW-1:0];
                    rd_addr  = pos_inc[AW-1:0];
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = index_wide[IDX_W-1:0];
                    out_last_next  = (draws_inc == loaded_reg);
                    draws_next     = draws_inc;
                    ptr_next       = ptr_sum[FRAC_BITS-1:0];
                    if (ptr_sum[FRAC_BITS])
                    begin
                        pos_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            draws_reg     <= '0;
            step_reg      <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            draws_reg     <= draws_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    // prefix-sum store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= sum_mem[rd_addr];
    end

    `SRS_ASSERT_IMPL(a_draws_le_loaded, clk, rst_n, 1'b1, draws_reg <= loaded_reg)
    `SRS_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN, pos_ext < loaded_reg)
    `SRS_ASSERT_IMPL(a_emit_from_scan, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_SCAN)

endmodule
